// ===== hdl/rational_reduce_defines.svh =====
// Assertion macros used by rational_reduce, the fraction reducer's top module.
// Both macros sample on the rising edge of clock and are off while reset is high.
`ifndef RATIONAL_REDUCE_DEFINES_SVH
`define RATIONAL_REDUCE_DEFINES_SVH

// Checks a condition at every rising clock edge.
`define RR_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define RR_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hdl/rr_pkg.sv =====
`default_nettype none

package rr_pkg;

   typedef enum logic [3:0] {
      RR_IDLE,
      RR_RX_GO,
      RR_RX_WAIT,
      RR_RY_GO,
      RR_RY_WAIT,
      RR_DN_GO,
      RR_DN_WAIT,
      RR_DD_GO,
      RR_DD_WAIT,
      RR_FIN
   } rr_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rr_div_stat_type;

   localparam logic [1:0] RR_ST_OK       = 2'd0;
   localparam logic [1:0] RR_ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] RR_ST_OVERFLOW = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/rational_reduce.sv =====
// Channel | Direction | Transaction contents
// req     | in        | tdata: numer_in, denom_in
// rsp     | out       | tdata: numer_out, denom_out; tuser: is_whole, status
//
// Each transaction makes k + 2 passes through the one bit-per-cycle divider, where k is
// the number of Euclid remainder steps (at most about 1.44 * WIDTH). A whole result
// needs one pass less, and a zero denominator skips the divider. req_tready is high
// only between transactions; a result waiting in the output register stalls only the
// next finish. Synchronous reset clears FSM and valid.
`default_nettype none
`include "rational_reduce_defines.svh"

module rational_reduce #(
   parameter int WIDTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // numer_in [WIDTH-1:0], denom_in [2*WIDTH-1:WIDTH], zero padding above
   input  wire logic [((2*WIDTH+7)/8)*8-1:0]         req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // numer_out [WIDTH-1:0], denom_out [2*WIDTH-2:WIDTH], zero padding above
   output logic [((2*WIDTH-1+7)/8)*8-1:0]            rsp_tdata,
   // is_whole [0], status [2:1]
   output logic [2:0]                                rsp_tuser
);
   import rr_pkg::*;

   localparam int OUT_TDATA_W = ((2*WIDTH-1+7)/8)*8;
   localparam logic [WIDTH-1:0] HALF = {1'b1, {(WIDTH-1){1'b0}}};

   rr_state_type state_ff, state_in;

   logic             sx_ff, sx_in;
   logic             sy_ff, sy_in;
   logic             gs_ff, gs_in;
   logic             zero_ff, zero_in;
   logic             whole_ff, whole_in;
   logic [WIDTH-1:0] nmag_ff, nmag_in;
   logic [WIDTH-1:0] dmag_ff, dmag_in;
   logic [WIDTH-1:0] xmag_ff, xmag_in;
   logic [WIDTH-1:0] ymag_ff, ymag_in;
   logic [WIDTH-1:0] gmag_ff, gmag_in;
   logic [WIDTH-1:0] qn_ff, qn_in;
   logic [WIDTH-1:0] qd_ff, qd_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0] rsp_numer_ff, rsp_numer_in;
   logic [WIDTH-2:0] rsp_denom_ff, rsp_denom_in;
   logic             rsp_whole_ff, rsp_whole_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;

   logic [WIDTH-1:0] numer_w, denom_w;
   logic             div_start;
   logic [WIDTH-1:0] div_a, div_b, div_quo, div_rem;
   rr_div_stat_type  div_stat;

   logic             out_free, rsp_load;
   logic             nsign, ovf_whole, ovf_frac;
   logic [WIDTH-1:0] numer_val;
   logic             div_wait, rsp_ok;

   assign numer_w  = req_tdata[WIDTH-1:0];
   assign denom_w  = req_tdata[2*WIDTH-1:WIDTH];
   assign out_free = ~rsp_valid_ff | rsp_tready;

   rr_div #(
      .WIDTH (WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .quotient  (div_quo),
      .remainder (div_rem),
      .stat      (div_stat)
   );

   // Truncating division works on magnitudes: the quotient sign is the xor of the
   // operand signs, and the remainder keeps the sign of the dividend, so x and y
   // keep their input signs through the whole Euclid loop.
   assign nsign     = sx_ff ^ sy_ff;
   assign numer_val = nsign ? (-qn_ff) : qn_ff;
   assign ovf_whole = (qn_ff == HALF) && !nsign;
   // The reduced numerator overflows as a positive quotient, or as the most
   // negative value when the denominator needs its sign flipped.
   assign ovf_frac  = ((qn_ff == HALF) && (!(sx_ff ^ gs_ff) || (sy_ff ^ gs_ff))) ||
                      (qd_ff == HALF);

   always_comb begin
      state_in      = state_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      gs_in         = gs_ff;
      zero_in       = zero_ff;
      whole_in      = whole_ff;
      nmag_in       = nmag_ff;
      dmag_in       = dmag_ff;
      xmag_in       = xmag_ff;
      ymag_in       = ymag_ff;
      gmag_in       = gmag_ff;
      qn_in         = qn_ff;
      qd_in         = qd_ff;
      div_start     = 1'b0;
      div_a         = xmag_ff;
      div_b         = ymag_ff;
      rsp_load      = 1'b0;
      req_tready    = 1'b0;

      unique case (state_ff)
         RR_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               sx_in    = numer_w[WIDTH-1];
               sy_in    = denom_w[WIDTH-1];
               nmag_in  = numer_w[WIDTH-1] ? (-numer_w) : numer_w;
               xmag_in  = numer_w[WIDTH-1] ? (-numer_w) : numer_w;
               dmag_in  = denom_w[WIDTH-1] ? (-denom_w) : denom_w;
               ymag_in  = denom_w[WIDTH-1] ? (-denom_w) : denom_w;
               zero_in  = (denom_w == '0);
               state_in = (denom_w == '0) ? RR_FIN : RR_RX_GO;
            end
         end
         RR_RX_GO: begin
            div_start = 1'b1;
            div_a     = xmag_ff;
            div_b     = ymag_ff;
            state_in  = RR_RX_WAIT;
         end
         RR_RX_WAIT: begin
            if (div_stat.done) begin
               xmag_in = div_rem;
               if (div_rem == '0) begin
                  gs_in    = sy_ff;
                  gmag_in  = ymag_ff;
                  whole_in = (ymag_ff == dmag_ff);
                  state_in = RR_DN_GO;
               end else begin
                  state_in = RR_RY_GO;
               end
            end
         end
         RR_RY_GO: begin
            div_start = 1'b1;
            div_a     = ymag_ff;
            div_b     = xmag_ff;
            state_in  = RR_RY_WAIT;
         end
         RR_RY_WAIT: begin
            if (div_stat.done) begin
               ymag_in = div_rem;
               if (div_rem == '0) begin
                  gs_in    = sx_ff;
                  gmag_in  = xmag_ff;
                  whole_in = (sx_ff == sy_ff) && (xmag_ff == dmag_ff);
                  state_in = RR_DN_GO;
               end else begin
                  state_in = RR_RX_GO;
               end
            end
         end
         RR_DN_GO: begin
            // When the result is whole the gcd magnitude equals the denominator's.
            div_start = 1'b1;
            div_a     = nmag_ff;
            div_b     = gmag_ff;
            state_in  = RR_DN_WAIT;
         end
         RR_DN_WAIT: begin
            if (div_stat.done) begin
               qn_in    = div_quo;
               state_in = whole_ff ? RR_FIN : RR_DD_GO;
            end
         end
         RR_DD_GO: begin
            div_start = 1'b1;
            div_a     = dmag_ff;
            div_b     = gmag_ff;
            state_in  = RR_DD_WAIT;
         end
         RR_DD_WAIT: begin
            if (div_stat.done) begin
               qd_in    = div_quo;
               state_in = RR_FIN;
            end
         end
         RR_FIN: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = RR_IDLE;
            end
         end
         default: begin
            state_in = RR_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_numer_in  = rsp_numer_ff;
      rsp_denom_in  = rsp_denom_ff;
      rsp_whole_in  = rsp_whole_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_numer_in  = '0;
         rsp_denom_in  = '0;
         rsp_whole_in  = 1'b0;
         priority if (zero_ff) begin
            rsp_status_in = RR_ST_ZERO_DEN;
         end else if (whole_ff ? ovf_whole : ovf_frac) begin
            rsp_status_in = RR_ST_OVERFLOW;
         end else if (whole_ff) begin
            rsp_status_in = RR_ST_OK;
            rsp_numer_in  = numer_val;
            rsp_denom_in  = (WIDTH-1)'(1);
            rsp_whole_in  = 1'b1;
         end else begin
            rsp_status_in = RR_ST_OK;
            rsp_numer_in  = numer_val;
            rsp_denom_in  = qd_ff[WIDTH-2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= RR_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      gs_ff         <= gs_in;
      zero_ff       <= zero_in;
      whole_ff      <= whole_in;
      nmag_ff       <= nmag_in;
      dmag_ff       <= dmag_in;
      xmag_ff       <= xmag_in;
      ymag_ff       <= ymag_in;
      gmag_ff       <= gmag_in;
      qn_ff         <= qn_in;
      qd_ff         <= qd_in;
      rsp_numer_ff  <= rsp_numer_in;
      rsp_denom_ff  <= rsp_denom_in;
      rsp_whole_ff  <= rsp_whole_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(OUT_TDATA_W-2*WIDTH+1){1'b0}}, rsp_denom_ff, rsp_numer_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_whole_ff};

   assign div_wait = (state_ff == RR_RX_WAIT) || (state_ff == RR_RY_WAIT) ||
                     (state_ff == RR_DN_WAIT) || (state_ff == RR_DD_WAIT);
   assign rsp_ok   = rsp_valid_ff && (rsp_status_ff == RR_ST_OK);

   `RR_ASSERT_IMPLY(a_div_start_idle, div_start, !div_stat.busy, "divider started while busy")
   `RR_ASSERT_IMPLY(a_div_done_wait, div_stat.done, div_wait, "divider done outside a wait")
   `RR_ASSERT_NOW(a_start_done_excl, $onehot0({div_start, div_stat.done}), "start and done coincide")
   `RR_ASSERT_IMPLY(a_ok_denom, rsp_ok, rsp_denom_ff != '0, "reduced denominator is zero")

endmodule

`default_nettype wire

// ===== hdl/rr_div.sv =====
`default_nettype none

// Unsigned restoring divider. One quotient bit per cycle: the dividend shifts
// out of the top of quo_ff into the partial remainder while quotient bits shift
// in at the bottom.
module rr_div #(
   parameter int WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [WIDTH-1:0]        dividend,
   input  wire logic [WIDTH-1:0]        divisor,
   output logic [WIDTH-1:0]             quotient,
   output logic [WIDTH-1:0]             remainder,
   output rr_pkg::rr_div_stat_type      stat
);
   import rr_pkg::*;

   localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;

   logic [WIDTH-1:0] shifted;
   logic [WIDTH:0]   diff;
   logic             fits;

   // Remainder < divisor <= 2**(WIDTH-1), so shifted value fits WIDTH bits.
   assign shifted = {rem_ff[WIDTH-2:0], quo_ff[WIDTH-1]};
   assign diff    = {1'b0, shifted} - {1'b0, dsr_ff};
   assign fits    = ~diff[WIDTH];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (busy_ff) begin
         rem_in = fits ? diff[WIDTH-1:0] : shifted;
         quo_in = {quo_ff[WIDTH-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WIDTH - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign stat.busy   = busy_ff;
   assign stat.done   = done_ff;

endmodule

`default_nettype wire

// ===== verif/tb_rational_reduce.sv =====
`timescale 1ns / 1ps

module tb_rational_reduce;
   import rr_pkg::*;

   localparam int WIDTH = 32;
   localparam longint WMAX = (64'sd1 <<< (WIDTH - 1)) - 1;
   localparam longint WMIN = -(64'sd1 <<< (WIDTH - 1));
   localparam int RANDOM_FRACTIONS = 1600;
   localparam int DRAIN_CYCLES = 2000;
   // Worst case is about 48 divider passes for each fraction.
   localparam longint CYCLE_LIMIT = 64'd12_000_000;

   typedef struct packed {
      logic [WIDTH-1:0] numer;
      logic [WIDTH-2:0] denom;
      logic             whole;
      logic [1:0]       status;
   } reduced_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;

   logic [63:0]  fraction_q[$];
   reduced_type  reduced_q[$];
   logic         req_fire = 1'b0;
   int           accepted_count = 0;
   int           mismatch_count = 0;
   longint       cycle_count = 0;
   bit           quiet;

   rational_reduce #(.WIDTH(WIDTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   function automatic logic [63:0] pack_fraction(input int numer, input int denom);
      return {denom, numer};
   endfunction

   // Signed value in [-mag, mag].
   function automatic longint rand_signed(input int unsigned mag);
      longint v;
      v = longint'($urandom_range(mag));
      return $urandom_range(1) ? -v : v;
   endfunction

   // Zero-denominator check, Euclid with truncating remainder, then whole-number or reduced-fraction result.
   function automatic reduced_type predict_reduced(input logic [63:0] fraction);
      longint n, d, x, y, g, n1, d1;
      bit ovf, done;
      reduced_type r;
      r = '0;
      r.status = RR_ST_OK;
      n = longint'($signed(fraction[WIDTH-1:0]));
      d = longint'($signed(fraction[2*WIDTH-1:WIDTH]));
      if (d == 0) begin
         r.status = RR_ST_ZERO_DEN;
         return r;
      end
      x = n;
      y = d;
      g = d;
      done = 1'b0;
      while (!done) begin
         x = x % y;
         if (x == 0) begin
            g = y;
            done = 1'b1;
         end else begin
            y = y % x;
            if (y == 0) begin
               g = x;
               done = 1'b1;
            end
         end
      end
      ovf = 1'b0;
      if (g == d) begin
         n1 = n / d;
         if (n1 > WMAX || n1 < WMIN) begin
            r.status = RR_ST_OVERFLOW;
         end else begin
            r.numer = n1[WIDTH-1:0];
            r.denom = (WIDTH-1)'(1);
            r.whole = 1'b1;
         end
         return r;
      end
      n1 = n / g;
      d1 = d / g;
      if (n1 > WMAX || n1 < WMIN || d1 > WMAX || d1 < WMIN) ovf = 1'b1;
      if (!ovf && d1 < 0) begin
         // The sign fix negates both; the most negative value has no positive twin.
         if (n1 == WMIN || d1 == WMIN) begin
            ovf = 1'b1;
         end else begin
            n1 = -n1;
            d1 = -d1;
         end
      end
      if (ovf) begin
         r.status = RR_ST_OVERFLOW;
      end else begin
         r.numer = n1[WIDTH-1:0];
         r.denom = d1[WIDTH-2:0];
      end
      return r;
   endfunction

   function automatic logic [63:0] make_fraction();
      int unsigned kind;
      longint n, d, f;
      longint specials[8];
      specials = '{0, 1, -1, WMIN, WMAX, WMIN + 1, 2, -2};
      kind = $urandom_range(99);
      if (kind < 30) begin
         return {$urandom(), $urandom()};
      end else if (kind < 55) begin
         // Shared factor, so the reduction actually divides something out.
         f = longint'($urandom_range(2000, 1));
         n = rand_signed(32767) * f;
         d = rand_signed(32767) * f;
      end else if (kind < 70) begin
         d = rand_signed(1000);
         n = rand_signed(1 << 20) * d;
      end else if (kind < 80) begin
         n = specials[$urandom_range(7)];
         d = $urandom_range(1) ? specials[$urandom_range(7)] : longint'($signed($urandom()));
         if ($urandom_range(1)) begin
            f = n;
            n = d;
            d = f;
         end
      end else if (kind < 85) begin
         n = longint'($signed($urandom()));
         d = 0;
      end else begin
         n = longint'($signed($urandom() >> $urandom_range(31)));
         d = longint'($signed($urandom() >> $urandom_range(31)));
         if ($urandom_range(1)) n = -n;
         if ($urandom_range(1)) d = -d;
      end
      return {d[WIDTH-1:0], n[WIDTH-1:0]};
   endfunction

   // The ready/valid idling pauses entirely for a stretch in the middle of the run.
   always_comb quiet = (accepted_count >= 600 && accepted_count < 900);

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_fire) begin
            if (fraction_q.size() > 0 && (quiet || $urandom_range(99) >= 9)) begin
               req_tdata  <= fraction_q.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= quiet || $urandom_range(99) >= 9;
      end
   end

   always @(posedge clock) begin
      reduced_type want, got;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, reduced_q.size());
         $display("status: fail");
         $finish;
      end
      req_fire <= req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.numer  = rsp_tdata[WIDTH-1:0];
         got.denom  = rsp_tdata[2*WIDTH-2:WIDTH];
         got.whole  = rsp_tuser[0];
         got.status = rsp_tuser[2:1];
         if (reduced_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result transaction: numer %0d denom %0d whole %0d status %0d",
                        $signed(got.numer), got.denom, got.whole, got.status);
         end else begin
            want = reduced_q.pop_front();
            if (got.numer !== want.numer || got.denom !== want.denom ||
                got.whole !== want.whole || got.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp n %0d d %0d w %0d s %0d, got n %0d d %0d w %0d s %0d",
                           $signed(want.numer), want.denom, want.whole, want.status,
                           $signed(got.numer), got.denom, got.whole, got.status);
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         reduced_q.push_back(predict_reduced(req_tdata));
         accepted_count <= accepted_count + 1;
      end
   end

   initial begin
      fraction_q.push_back(pack_fraction(0, 5));
      fraction_q.push_back(pack_fraction(0, -7));
      fraction_q.push_back(pack_fraction(5, 0));
      fraction_q.push_back(pack_fraction(0, 0));
      fraction_q.push_back(pack_fraction(32'h8000_0000, -1));
      fraction_q.push_back(pack_fraction(32'h8000_0000, 1));
      fraction_q.push_back(pack_fraction(32'h8000_0000, 32'h8000_0000));
      fraction_q.push_back(pack_fraction(32'h7fff_ffff, 32'h7fff_ffff));
      fraction_q.push_back(pack_fraction(32'h7fff_ffff, -1));
      fraction_q.push_back(pack_fraction(32'h7fff_ffff, 32'h8000_0000));
      fraction_q.push_back(pack_fraction(32'h8000_0000, 32'h7fff_ffff));
      fraction_q.push_back(pack_fraction(32'h8000_0000, 2));
      fraction_q.push_back(pack_fraction(32'h8000_0000, 6));
      fraction_q.push_back(pack_fraction(32'h8000_0000, -6));
      fraction_q.push_back(pack_fraction(32'h8000_0000, -3));
      fraction_q.push_back(pack_fraction(1, 32'h8000_0000));
      fraction_q.push_back(pack_fraction(3, 32'h8000_0000));
      fraction_q.push_back(pack_fraction(6, -4));
      fraction_q.push_back(pack_fraction(-6, 4));
      fraction_q.push_back(pack_fraction(4, -2));
      fraction_q.push_back(pack_fraction(-1, -1));
      fraction_q.push_back(pack_fraction(1, -1));
      fraction_q.push_back(pack_fraction(12, 18));
      fraction_q.push_back(pack_fraction(-3, 7));
      fraction_q.push_back(pack_fraction(32'hffff_ffff, 32'h7fff_fffe));
      for (int i = 0; i < RANDOM_FRACTIONS; i++)
         fraction_q.push_back(make_fraction());

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (fraction_q.size() == 0 && !req_tvalid);
      wait (reduced_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && reduced_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
